@@ rtl/wto_pkg.sv @@
package wto_pkg;

  localparam int TABLE_DEPTH = 2048;
  localparam int SAMPLE_W    = 16;
  localparam int PHASE_W     = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int TSIZE_W     = 12;
  localparam int FRAC_W      = 16;
  localparam int WGT_W       = FRAC_W + 1;
  localparam int TPOS_W      = PHASE_W + TSIZE_W;
  localparam int PROD_W      = SAMPLE_W + WGT_W + 1;
  localparam int MIX_W       = PROD_W + WGT_W + 1;
  localparam int Y_W         = MIX_W - 2 * FRAC_W;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_RESET  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_MIX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_RUN   = 3'd4;

  typedef struct packed {
    logic [1:0]                 action;
    logic [31:0]                fm_offset;
    logic                       wave_select;
    logic [10:0]                table_address;
    logic signed [SAMPLE_W-1:0] table_value;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
  } result_t;

  typedef struct packed {
    logic load_item;
    logic write_table;
    logic reset_phase;
    logic load_out;
  } cmd_t;

endpackage

@@ rtl/wto_ifs.sv @@
interface wto_item_if;
  import wto_pkg::*;
  logic  valid;
  logic  ready;
  item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface wto_result_if;
  import wto_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/wavetable_oscillator_interp.sv @@
// channel  direction  handshake      payload
// item     in         valid/ready    action, fm_offset, wave_select, table_address, table_value
// result   out        valid/ready    sample
// config   in         write_enable   reg_index, write_data
//
// Table writes and phase resets are done as the item is accepted; a sample goes
// through accept, position multiply, table read, interpolation products, crossfade
// products, and round and output, set by the multiply chain around the table RAMs.
// rst is synchronous: phase 0, registers to their defaults, tables left as they are.
// A finished sample waits in the output register; a second one stalls in the
// last step while that register is full and not being taken.
module wavetable_oscillator_interp (
  input  logic                            clk,
  input  logic                            rst,
  wto_item_if.sink                        item,
  wto_result_if.source                    result,
  input  logic                            write_enable,
  input  logic [wto_pkg::CFG_IDX_W-1:0]   reg_index,
  input  logic [wto_pkg::CFG_DATA_W-1:0]  write_data
);
  import wto_pkg::*;

  cmd_t cmd;

  wto_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .action       (item.payload.action),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd)
  );

  wto_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item_data    (item.payload),
    .result_data  (result.payload),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

endmodule

@@ rtl/wto_ram.sv @@
module wto_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

@@ rtl/wto_ctrl.sv @@
module wto_ctrl (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic [1:0]  action,
  output logic        item_ready,
  output logic        result_valid,
  input  logic        result_ready,
  output wto_pkg::cmd_t cmd
);
  import wto_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_ADDR   = 6'b000100,
    S_INTERP = 6'b001000,
    S_MIX    = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;
  logic   accept;

  assign item_ready   = (state == S_IDLE);
  assign result_valid = out_valid;
  assign accept       = item_valid && item_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_SAMPLE: begin
              cmd.load_item = 1'b1;
              state_next    = S_MUL;
            end
            ACT_WRITE: cmd.write_table = 1'b1;
            ACT_RESET: cmd.reset_phase = 1'b1;
            default: ;
          endcase
        end
      end
      S_MUL:    state_next = S_ADDR;
      S_ADDR:   state_next = S_INTERP;
      S_INTERP: state_next = S_MIX;
      S_MIX:    state_next = S_OUT;
      S_OUT: begin
        // hold here until the output register is free or being emptied
        if (!out_valid || result_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (result_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/wto_datapath.sv @@
module wto_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  wto_pkg::cmd_t                   cmd,
  input  wto_pkg::item_t                  item_data,
  output wto_pkg::result_t                result_data,
  input  logic                            write_enable,
  input  logic [wto_pkg::CFG_IDX_W-1:0]   reg_index,
  input  logic [wto_pkg::CFG_DATA_W-1:0]  write_data
);
  import wto_pkg::*;

  localparam logic [WGT_W-1:0]         ONE   = WGT_W'(1) << FRAC_W;
  localparam logic signed [MIX_W-1:0]  ROUND = MIX_W'(1) << (2 * FRAC_W - 1);
  localparam logic [TSIZE_W-1:0]       TS_MAX = TSIZE_W'(TABLE_DEPTH);

  // configuration
  logic [PHASE_W-1:0]  phase_inc;
  logic [TSIZE_W-1:0]  table_size;
  logic [FRAC_W-1:0]   wave_mix;
  logic [PHASE_W-1:0]  start_phase;
  logic                free_running;

  logic [PHASE_W-1:0]  phase;
  logic [PHASE_W-1:0]  sum_r;
  logic [TSIZE_W-1:0]  ts_eff;
  logic [TPOS_W-1:0]   t_r;
  logic [ADDR_W-1:0]   i1, i2;
  logic [TSIZE_W-1:0]  i1_inc;
  logic [FRAC_W-1:0]   f_r;
  logic [WGT_W-1:0]    w1, mw1;

  logic [SAMPLE_W-1:0] rd_a1, rd_a2, rd_b1, rd_b2;
  logic signed [PROD_W-1:0] pa1, pa2, pb1, pb2;
  logic signed [PROD_W-1:0] wa, wb;
  logic signed [MIX_W-1:0]  ma, mb, acc;
  logic signed [Y_W-1:0]    y;
  logic [Y_W-SAMPLE_W:0]    y_hi;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic signed [SAMPLE_W-1:0] sample_r;

  logic we_a, we_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_inc    <= '0;
      table_size   <= TS_MAX;
      wave_mix     <= '0;
      start_phase  <= '0;
      free_running <= 1'b1;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_PHASE_INC:  phase_inc    <= write_data[PHASE_W-1:0];
        REG_TABLE_SIZE: table_size   <= write_data[TSIZE_W-1:0];
        REG_WAVE_MIX:   wave_mix     <= write_data[FRAC_W-1:0];
        REG_START:      start_phase  <= write_data[PHASE_W-1:0];
        REG_FREE_RUN:   free_running <= write_data[0];
        default: ;
      endcase
    end
  end

  // phase accumulator: the sample sees the phase before the advance
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (cmd.load_item) begin
      phase <= phase + phase_inc;
    end else if (cmd.reset_phase && !free_running) begin
      phase <= start_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      sum_r <= phase + item_data.fm_offset;
    end
  end

  assign ts_eff = (table_size > TS_MAX) ? TS_MAX : table_size;

  // table position: integer part is the index, next bits the fraction
  always_ff @(posedge clk) begin
    t_r <= TPOS_W'(sum_r) * TPOS_W'(ts_eff);
  end

  assign i1     = t_r[PHASE_W +: ADDR_W];
  assign i1_inc = {1'b0, i1} + TSIZE_W'(1);
  assign i2     = (i1_inc >= ts_eff) ? '0 : i1_inc[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    f_r <= t_r[PHASE_W-1 -: FRAC_W];
  end

  assign we_a = cmd.write_table && !item_data.wave_select;
  assign we_b = cmd.write_table &&  item_data.wave_select;

  wto_ram #(.WIDTH(SAMPLE_W), .DEPTH(TABLE_DEPTH)) u_ram_a (
    .clk    (clk),
    .we     (we_a),
    .waddr  (item_data.table_address[ADDR_W-1:0]),
    .wdata  (item_data.table_value),
    .raddr0 (i1),
    .raddr1 (i2),
    .rdata0 (rd_a1),
    .rdata1 (rd_a2)
  );

  wto_ram #(.WIDTH(SAMPLE_W), .DEPTH(TABLE_DEPTH)) u_ram_b (
    .clk    (clk),
    .we     (we_b),
    .waddr  (item_data.table_address[ADDR_W-1:0]),
    .wdata  (item_data.table_value),
    .raddr0 (i1),
    .raddr1 (i2),
    .rdata0 (rd_b1),
    .rdata1 (rd_b2)
  );

  assign w1 = ONE - {1'b0, f_r};

  always_ff @(posedge clk) begin
    pa1 <= $signed(rd_a1) * $signed({1'b0, w1});
    pa2 <= $signed(rd_a2) * $signed({2'b00, f_r});
    pb1 <= $signed(rd_b1) * $signed({1'b0, w1});
    pb2 <= $signed(rd_b2) * $signed({2'b00, f_r});
  end

  assign wa  = pa1 + pa2;
  assign wb  = pb1 + pb2;
  assign mw1 = ONE - {1'b0, wave_mix};

  always_ff @(posedge clk) begin
    ma <= wa * $signed({1'b0, mw1});
    mb <= wb * $signed({2'b00, wave_mix});
  end

  // round half up, floor shift, then saturate
  assign acc  = ma + mb + ROUND;
  assign y    = acc[MIX_W-1 -: Y_W];
  assign y_hi = y[Y_W-1:SAMPLE_W-1];

  always_comb begin
    if ((&y_hi) || !(|y_hi)) begin
      y_sat = y[SAMPLE_W-1:0];
    end else if (y[Y_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sample_r <= y_sat;
    end
  end

  assign result_data.sample = sample_r;

endmodule
